### rtl/core/pce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pce_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int HEADER_BITS  = 3;
    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int FILL_W       = 3;
    localparam int ACC_W        = 7;
    localparam int SUM_W        = CODE_W + ACC_W;
    localparam int CNT_W        = 3;
    localparam int ENTRY_W      = LEN_W + CODE_W;

    // transaction kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] pad_count;
        logic       is_last;
        logic       status;
    } t_out;

    // table entry, code held left aligned with zeros below its length
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    // item waiting in the lookup stage
    typedef struct packed {
        logic flush;
        logic hit;
    } t_s1;

    // burst of bytes handed to the output stage
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [CNT_W-1:0]  cnt;
        logic [2:0]        pad;
        logic              last;
        logic              status;
    } t_job;

endpackage

`default_nettype wire

### rtl/core/prefix_code_table_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction   handshake                  payload
// in        input       i_in_valid / o_in_ready    i_in_data  (pce_pkg::t_in)
// out       output      o_out_valid / i_out_ready  o_out_data (pce_pkg::t_out)
//
// a transaction is taken every cycle while the output keeps up and no burst has more than one byte left; an
// encode yields 0 to 4 bytes, one per cycle, and holds the lookup stage until its last byte is taken
// the code table lives in one 256 x 38 ram, with a registered read whose data is ready in the cycle after acceptance
// reset is synchronous; it clears the entry valid bits, the accumulator and
// loads the three header bits, the table ram itself is not cleared
// a stalled output holds the lookup stage, which then holds the input

module prefix_code_table_encoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire pce_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output pce_pkg::t_out     o_out_data
);

    // input stage
    logic                        w_in_acc;
    logic                        w_is_load;
    logic                        w_is_encode;
    logic                        w_is_flush;
    logic [pce_pkg::LEN_W-1:0]   w_len_sat;
    logic [pce_pkg::CODE_W-1:0]  w_code_left;
    pce_pkg::t_entry             w_wentry;
    pce_pkg::t_entry             w_rentry;

    // entry valid bits, cleared by reset
    logic [pce_pkg::TABLE_DEPTH-1:0] r_entry_vld;

    // lookup stage, waits here for the output stage to take its bytes
    logic          r_s1_vld;
    logic          n_s1_vld;
    pce_pkg::t_s1  r_s1;
    logic          w_commit;
    logic          w_free;
    pce_pkg::t_job w_job;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_is_load   = (i_in_data.kind == pce_pkg::KIND_LOAD);
    assign w_is_encode = (i_in_data.kind == pce_pkg::KIND_ENCODE);
    assign w_is_flush  = (i_in_data.kind == pce_pkg::KIND_FLUSH);

    assign w_commit   = r_s1_vld && w_free;
    assign o_in_ready = !r_s1_vld || w_free;

    // overlong lengths saturate; the code is stored left aligned and masked
    assign w_len_sat = (i_in_data.code_length > pce_pkg::LEN_W'(pce_pkg::MAX_CODE_LEN))
                     ? pce_pkg::LEN_W'(pce_pkg::MAX_CODE_LEN) : i_in_data.code_length;

    always_comb begin
        if (w_len_sat == '0) begin
            w_code_left = '0;
        end else begin
            w_code_left = i_in_data.code_bits
                        << (pce_pkg::LEN_W'(pce_pkg::CODE_W) - w_len_sat);
        end
    end

    assign w_wentry.len  = w_len_sat;
    assign w_wentry.code = w_code_left;

    // a load writes at its own edge, so an encode right behind it reads the new entry
    pce_ram #(
        .WIDTH (pce_pkg::ENTRY_W),
        .DEPTH (pce_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_is_load),
        .i_waddr (i_in_data.symbol[pce_pkg::ADDR_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_in_acc && w_is_encode),
        .i_raddr (i_in_data.symbol[pce_pkg::ADDR_W-1:0]),
        .o_rdata (w_rentry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
        end else if (w_in_acc && w_is_load) begin
            r_entry_vld[i_in_data.symbol[pce_pkg::ADDR_W-1:0]] <= 1'b1;
        end
    end

    // unused kind is taken and dropped
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_in_acc && (w_is_encode || w_is_flush)) begin
            n_s1_vld = 1'b1;
        end else if (w_commit) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_is_encode || w_is_flush)) begin
            r_s1.flush <= w_is_flush;
            r_s1.hit   <= r_entry_vld[i_in_data.symbol[pce_pkg::ADDR_W-1:0]];
        end
    end

    // bit accumulator and byte slicing
    pce_packer u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_commit),
        .i_s1     (r_s1),
        .i_entry  (w_rentry),
        .o_job    (w_job)
    );

    // output register, hands out one byte per cycle while the output is ready
    pce_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_commit),
        .i_job       (w_job),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // a waiting lookup keeps its place and kind
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_free) |=> (r_s1_vld && $stable(r_s1.flush)))
        else $error("lookup stage lost while stalled");

    // a load marks its entry valid
    a_load_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_load)
            |=> r_entry_vld[$past(i_in_data.symbol[pce_pkg::ADDR_W-1:0])])
        else $error("loaded entry not marked valid");

    // a miss produces exactly one status byte
    a_miss_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !r_s1.flush && !r_s1.hit)
            |-> (w_job.cnt == pce_pkg::CNT_W'(1) && w_job.status))
        else $error("missing entry not flagged");

endmodule

`default_nettype wire

### rtl/core/pce_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/pce_packer.sv
`timescale 1ns / 1ps
`default_nettype none

module pce_packer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_commit,
    input  wire pce_pkg::t_s1    i_s1,
    input  wire pce_pkg::t_entry i_entry,
    output pce_pkg::t_job        o_job
);

    logic [pce_pkg::ACC_W-1:0]  r_acc;
    logic [pce_pkg::ACC_W-1:0]  n_acc;
    logic [pce_pkg::FILL_W-1:0] r_fill;
    logic [pce_pkg::FILL_W-1:0] n_fill;

    logic [pce_pkg::LEN_W-1:0]  w_fill_sum;
    logic [pce_pkg::CNT_W-1:0]  w_nbytes;
    logic [pce_pkg::SUM_W-1:0]  w_sum;
    logic [pce_pkg::ACC_W-1:0]  w_rest;
    logic [7:0]                 w_flush_byte;

    // pending bits sit at the top, the new code goes straight under them
    assign w_sum = {r_acc, {pce_pkg::CODE_W{1'b0}}}
                 | ({i_entry.code, {pce_pkg::ACC_W{1'b0}}} >> r_fill);
    assign w_fill_sum = pce_pkg::LEN_W'(r_fill) + i_entry.len;
    assign w_nbytes   = w_fill_sum[pce_pkg::LEN_W-1:3];
    assign w_flush_byte = {r_acc, 1'b0} | (8'hFF >> r_fill);

    always_comb begin
        unique case (w_nbytes)
            3'd0:    w_rest = w_sum[38:32];
            3'd1:    w_rest = w_sum[30:24];
            3'd2:    w_rest = w_sum[22:16];
            3'd3:    w_rest = w_sum[14:8];
            3'd4:    w_rest = w_sum[6:0];
            default: w_rest = w_sum[38:32];
        endcase
    end

    always_comb begin
        o_job  = '0;
        n_acc  = r_acc;
        n_fill = r_fill;
        if (i_s1.flush) begin
            if (r_fill != '0) begin
                o_job.word = {w_flush_byte, 24'd0};
                o_job.cnt  = pce_pkg::CNT_W'(1);
                o_job.pad  = 3'(4'd8 - {1'b0, r_fill});
                o_job.last = 1'b1;
            end
            n_acc  = '0;
            n_fill = pce_pkg::FILL_W'(pce_pkg::HEADER_BITS);
        end else if (!i_s1.hit) begin
            o_job.cnt    = pce_pkg::CNT_W'(1);
            o_job.status = 1'b1;
        end else begin
            o_job.word = w_sum[pce_pkg::SUM_W-1 -: pce_pkg::CODE_W];
            o_job.cnt  = w_nbytes;
            n_acc      = w_rest;
            n_fill     = w_fill_sum[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= pce_pkg::FILL_W'(pce_pkg::HEADER_BITS);
        end else if (i_commit) begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
        end
    end

    // bits below the pending count are kept clear
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_acc << r_fill) == '0))
        else $error("accumulator holds stray bits");

endmodule

`default_nettype wire

### rtl/core/pce_emitter.sv
`timescale 1ns / 1ps
`default_nettype none

module pce_emitter (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire pce_pkg::t_job i_job,
    output logic              o_free,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output pce_pkg::t_out     o_out_data
);

    logic [pce_pkg::CODE_W-1:0] r_word;
    logic [pce_pkg::CNT_W-1:0]  r_cnt;
    logic [2:0]                 r_pad;
    logic                       r_last;
    logic                       r_status;
    logic                       w_pop;

    assign o_out_valid = (r_cnt != '0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_free      = (r_cnt == '0) || ((r_cnt == pce_pkg::CNT_W'(1)) && i_out_ready);

    assign o_out_data.out_byte  = r_word[pce_pkg::CODE_W-1 -: 8];
    assign o_out_data.pad_count = r_pad;
    assign o_out_data.is_last   = r_last;
    assign o_out_data.status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_job.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - pce_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word   <= i_job.word;
            r_pad    <= i_job.pad;
            r_last   <= i_job.last;
            r_status <= i_job.status;
        end else if (w_pop) begin
            r_word <= {r_word[pce_pkg::CODE_W-9:0], 8'd0};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= pce_pkg::CNT_W'(4)))
        else $error("byte count out of range");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.is_last || o_out_data.status))
            |-> (r_cnt == pce_pkg::CNT_W'(1)))
        else $error("flagged byte inside a burst");

endmodule

`default_nettype wire
